>>> rtl/core/serial_freq_command_to_pwm_timer_assert.svh
// assertion macros for the serial frequency command block
// used by the controller; no other dependencies
`ifndef SERIAL_FREQ_COMMAND_TO_PWM_TIMER_ASSERT_SVH
`define SERIAL_FREQ_COMMAND_TO_PWM_TIMER_ASSERT_SVH
`ifndef SYNTH
`define SFPT_ASSERT_IMM(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SFPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SFPT_ASSERT_IMM(lbl, clk, rst, ante, cons, msg)
`define SFPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/core/sfpt_pkg.sv
// shared constants, types and character tables for the serial frequency block
// no dependencies
package sfpt_pkg;

   localparam int LINE_CHARS = 31;
   localparam int CNT_W      = $clog2(LINE_CHARS + 1);
   localparam int ADDR_W     = $clog2(LINE_CHARS);

   localparam logic [26:0] CLOCK_HZ  = 27'd72000000;
   localparam logic [19:0] FREQ_MIN  = 20'd1000;
   localparam logic [19:0] FREQ_MAX  = 20'd100000;
   localparam logic [23:0] MAG_CAP   = 24'd1000000;
   localparam logic [4:0]  DIV_BITS  = 5'd26;

   localparam logic [2:0] ST_OK_LONG  = 3'd0;
   localparam logic [2:0] ST_OK_SHORT = 3'd1;
   localparam logic [2:0] ST_RANGE    = 3'd2;
   localparam logic [2:0] ST_HELP     = 3'd3;
   localparam logic [2:0] ST_FORMAT   = 3'd4;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   typedef struct packed {
      logic store_char;
      logic start_scan;
      logic read_char;
      logic proc_char;
      logic start_div;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_line_end;
      logic line_empty;
      logic scan_last;
      logic need_div;
      logic div_last;
      logic rsp_free;
   } stat_type;

   function automatic logic [7:0] freq_char(logic [2:0] i);
      case (i)
         3'd0:    return 8'h46;
         3'd1:    return 8'h52;
         3'd2:    return 8'h45;
         3'd3:    return 8'h51;
         default: return 8'h3D;
      endcase
   endfunction

   function automatic logic [7:0] short_char(logic i);
      return i ? 8'h3D : 8'h46;
   endfunction

   function automatic logic [7:0] help_char(logic [1:0] i);
      case (i)
         2'd0:    return 8'h48;
         2'd1:    return 8'h45;
         2'd2:    return 8'h4C;
         default: return 8'h50;
      endcase
   endfunction

endpackage

>>> rtl/core/sfpt_datapath.sv
// line store, command parser, iterative divider and result register
// depends on sfpt_pkg
module sfpt_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       req_rx_byte,
   input  logic             rsp_stall,
   input  sfpt_pkg::cmd_type  cmd,
   output sfpt_pkg::stat_type stat,
   output logic             rsp_valid,
   output logic [2:0]       rsp_reply_status,
   output logic [16:0]      rsp_new_frequency,
   output logic             rsp_prescale_value,
   output logic [15:0]      rsp_reload_value,
   output logic [15:0]      rsp_compare_value
);
   import sfpt_pkg::*;

   localparam logic [1:0] NUM_BLANK = 2'd0;
   localparam logic [1:0] NUM_DIGIT = 2'd1;
   localparam logic [1:0] NUM_DONE  = 2'd2;

   logic [7:0]        line_mem [LINE_CHARS];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  clen_ff, clen_in;
   logic [7:0]        char_ff;
   logic              m_freq_ff, m_freq_in, m_short_ff, m_short_in, m_help_ff, m_help_in;
   logic [1:0]        num_ff, num_in;
   logic              neg_ff, neg_in;
   logic [19:0]       mag_ff, mag_in;
   logic [16:0]       rem_ff, rem_in, quo_ff, quo_in;
   logic [4:0]        bit_ff, bit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        status_ff;
   logic [16:0]       freq_ff;
   logic              psc_ff;
   logic [15:0]       arr_ff, ccr_ff;

   logic [CNT_W-1:0]  idx_next;
   logic              is_digit, is_blank, is_sign, active;
   logic [23:0]       mag_calc;
   logic              is_freq, is_short, is_help, in_range;
   logic [2:0]        status_calc;
   logic [17:0]       trial;
   logic              ge;
   logic [16:0]       arr_calc, ccr_calc;

   // line store
   always_ff @(posedge clock) begin
      if (cmd.store_char && count_ff < CNT_W'(LINE_CHARS)) begin
         line_mem[count_ff[ADDR_W-1:0]] <= req_rx_byte;
      end
      if (cmd.read_char) begin
         char_ff <= line_mem[idx_ff[ADDR_W-1:0]];
      end
   end

   assign idx_next = idx_ff + CNT_W'(1);
   assign is_digit = char_ff >= 8'h30 && char_ff <= 8'h39;
   assign is_blank = char_ff == 8'h20 || (char_ff >= 8'h09 && char_ff <= 8'h0D);
   assign is_sign  = char_ff == 8'h2B || char_ff == 8'h2D;
   assign active   = (m_freq_ff && idx_ff >= CNT_W'(5)) || (m_short_ff && idx_ff >= CNT_W'(2));
   assign mag_calc = ({4'd0, mag_ff} << 3) + ({4'd0, mag_ff} << 1) + {20'd0, char_ff[3:0]};

   always_comb begin
      count_in   = count_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      clen_in    = clen_ff;
      m_freq_in  = m_freq_ff;
      m_short_in = m_short_ff;
      m_help_in  = m_help_ff;
      num_in     = num_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      if (cmd.store_char && count_ff < CNT_W'(LINE_CHARS)) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.start_scan) begin
         len_in     = count_ff;
         count_in   = '0;
         idx_in     = '0;
         clen_in    = '0;
         m_freq_in  = 1'b1;
         m_short_in = 1'b1;
         m_help_in  = 1'b1;
         num_in     = NUM_BLANK;
         neg_in     = 1'b0;
         mag_in     = '0;
      end
      if (cmd.proc_char && char_ff != 8'h00) begin
         idx_in  = idx_next;
         clen_in = idx_next;
         if (idx_ff < CNT_W'(5) && char_ff != freq_char(idx_ff[2:0])) m_freq_in = 1'b0;
         if (idx_ff < CNT_W'(2) && char_ff != short_char(idx_ff[0])) m_short_in = 1'b0;
         if (idx_ff < CNT_W'(4) && char_ff != help_char(idx_ff[1:0])) m_help_in = 1'b0;
         if (active) begin
            case (num_ff)
               NUM_BLANK: begin
                  if (is_blank) begin
                     num_in = NUM_BLANK;
                  end else if (is_sign) begin
                     neg_in = char_ff == 8'h2D;
                     num_in = NUM_DIGIT;
                  end else if (is_digit) begin
                     mag_in = mag_calc > MAG_CAP ? MAG_CAP[19:0] : mag_calc[19:0];
                     num_in = NUM_DIGIT;
                  end else begin
                     num_in = NUM_DONE;
                  end
               end
               NUM_DIGIT: begin
                  if (is_digit) begin
                     mag_in = mag_calc > MAG_CAP ? MAG_CAP[19:0] : mag_calc[19:0];
                  end else begin
                     num_in = NUM_DONE;
                  end
               end
               default: num_in = NUM_DONE;
            endcase
         end
      end
   end

   // final decode of the scanned line
   assign is_freq  = m_freq_ff && clen_ff >= CNT_W'(5);
   assign is_short = m_short_ff && clen_ff >= CNT_W'(2);
   assign is_help  = m_help_ff && clen_ff == CNT_W'(4);
   assign in_range = !(neg_ff && mag_ff != '0) && mag_ff >= FREQ_MIN && mag_ff <= FREQ_MAX;

   always_comb begin
      if (is_freq) begin
         status_calc = in_range ? ST_OK_LONG : ST_RANGE;
      end else if (is_short) begin
         status_calc = in_range ? ST_OK_SHORT : ST_RANGE;
      end else if (is_help) begin
         status_calc = ST_HELP;
      end else begin
         status_calc = ST_FORMAT;
      end
   end

   // restoring divider, one quotient bit a cycle
   assign trial = {rem_ff, CLOCK_HZ[bit_ff]};
   assign ge    = trial >= {1'b0, mag_ff[16:0]};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      bit_in = bit_ff;
      if (cmd.start_div) begin
         rem_in = '0;
         quo_in = '0;
         bit_in = DIV_BITS;
      end else if (cmd.div_step) begin
         rem_in = ge ? 17'(trial - {1'b0, mag_ff[16:0]}) : trial[16:0];
         quo_in = {quo_ff[15:0], ge};
         bit_in = bit_ff - 5'd1;
      end
   end

   assign arr_calc = quo_ff[16] ? ({1'b0, quo_ff[16:1]} - 17'd1) : (quo_ff - 17'd1);
   assign ccr_calc = (arr_calc + 17'd1) >> 1;

   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_valid_ff && !rsp_stall ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff     <= len_in;
      idx_ff     <= idx_in;
      clen_ff    <= clen_in;
      m_freq_ff  <= m_freq_in;
      m_short_ff <= m_short_in;
      m_help_ff  <= m_help_in;
      num_ff     <= num_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      bit_ff     <= bit_in;
      if (cmd.load_rsp) begin
         status_ff <= status_calc;
         if (status_calc == ST_OK_LONG || status_calc == ST_OK_SHORT) begin
            freq_ff <= mag_ff[16:0];
            psc_ff  <= quo_ff[16];
            arr_ff  <= arr_calc[15:0];
            ccr_ff  <= ccr_calc[15:0];
         end else begin
            freq_ff <= '0;
            psc_ff  <= 1'b0;
            arr_ff  <= '0;
            ccr_ff  <= '0;
         end
      end
   end

   assign stat.is_line_end = req_rx_byte == CH_CR || req_rx_byte == CH_LF;
   assign stat.line_empty  = count_ff == '0;
   assign stat.scan_last   = char_ff == 8'h00 || idx_next == len_ff;
   assign stat.need_div    = status_calc == ST_OK_LONG || status_calc == ST_OK_SHORT;
   assign stat.div_last    = bit_ff == 5'd0;
   assign stat.rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reply_status   = status_ff;
   assign rsp_new_frequency  = freq_ff;
   assign rsp_prescale_value = psc_ff;
   assign rsp_reload_value   = arr_ff;
   assign rsp_compare_value  = ccr_ff;

endmodule

>>> rtl/core/sfpt_ctrl.sv
// controller state machine: sequences store, scan, divide and result load
// depends on sfpt_pkg and the assertion macro header
module sfpt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sfpt_pkg::stat_type stat,
   output sfpt_pkg::cmd_type  cmd
);
   import sfpt_pkg::*;
`include "serial_freq_command_to_pwm_timer_assert.svh"

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_PROC = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!stat.is_line_end) begin
                  cmd.store_char = 1'b1;
               end else if (!stat.line_empty) begin
                  cmd.start_scan = 1'b1;
                  state_in       = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.read_char = 1'b1;
            state_in      = S_PROC;
         end
         S_PROC: begin
            cmd.proc_char = 1'b1;
            state_in      = stat.scan_last ? S_FIN : S_READ;
         end
         S_FIN: begin
            if (stat.need_div) begin
               cmd.start_div = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_OUT;
         end
         S_OUT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SFPT_ASSERT_NEXT(a_div_to_out, clock, reset, state_ff == S_DIV && stat.div_last, state_ff == S_OUT, "divider end did not reach result load")
   `SFPT_ASSERT_IMM(a_load_free, clock, reset, cmd.load_rsp, stat.rsp_free, "result loaded over a waiting beat")
   `SFPT_ASSERT_NEXT(a_read_proc, clock, reset, state_ff == S_READ, state_ff == S_PROC && cmd.proc_char, "read not followed by char processing")

endmodule

>>> rtl/core/serial_freq_command_to_pwm_timer.sv
// top level of the serial frequency command to pwm timer block
// depends on sfpt_pkg, sfpt_ctrl and sfpt_datapath
//
// usage
//  - req channel: one received serial byte per beat (req_rx_byte)
//  - rsp channel: one reply beat per non-empty line: status, frequency,
//    prescaler, reload and compare values
//  - ordinary characters are stored as they are taken; up to 31 are kept,
//    later ones are dropped
//  - a cr or lf ends the line; an empty line gives no reply
//  - after a line end the stored line is scanned, each character read
//    and then processed; for an in-range value a restoring divider
//    (72 MHz / f) then runs, one quotient bit per cycle, before the
//    reply beat is loaded
//  - req_stall stays high while a line is scanned or divided and until
//    its reply is loaded; the scan loop and the divider set the rate
//  - the reply sits in an output register; new bytes are taken while
//    it waits, and a following line waits only to load the reply
//  - synchronous reset empties the line and drops any pending reply
module serial_freq_command_to_pwm_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_reply_status,
   output logic [16:0] rsp_new_frequency,
   output logic        rsp_prescale_value,
   output logic [15:0] rsp_reload_value,
   output logic [15:0] rsp_compare_value
);
   import sfpt_pkg::*;

   // command and status between controller and datapath
   cmd_type  cmd;
   stat_type stat;

   sfpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sfpt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_rx_byte        (req_rx_byte),
      .rsp_stall          (rsp_stall),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_reply_status   (rsp_reply_status),
      .rsp_new_frequency  (rsp_new_frequency),
      .rsp_prescale_value (rsp_prescale_value),
      .rsp_reload_value   (rsp_reload_value),
      .rsp_compare_value  (rsp_compare_value)
   );

endmodule

>>> tb/serial_freq_command_to_pwm_timer_tb.sv
// testbench for the serial frequency command to pwm timer block
// depends on sfpt_pkg and serial_freq_command_to_pwm_timer
module serial_freq_command_to_pwm_timer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfpt_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [16:0] freq;
      logic        psc;
      logic [15:0] reload;
      logic [15:0] compare;
   } reply_t;

   // one directed row: a whole line of text, and optionally a typed reply
   typedef struct {
      string  text;
      bit     typed;
      reply_t reply;
   } line_row_t;

   localparam int CYCLE_LIMIT = 2000000;

   // a tilde in a directed row is sent as a zero byte
   localparam logic [7:0] ZERO_MARK = 8'h7E;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_reply_status;
   logic [16:0] rsp_new_frequency;
   logic        rsp_prescale_value;
   logic [15:0] rsp_reload_value;
   logic [15:0] rsp_compare_value;

   serial_freq_command_to_pwm_timer uut (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // predictor state: the line held so far and the last accepted frequency
   logic [7:0]  line_chars [LINE_CHARS];
   int          line_len;
   logic [16:0] freq_now;

   reply_t      pending_replies [$];
   bit          failed;
   int          cycles;
   int          send_idle_pct;
   int          stall_pct;

   function automatic bit is_space(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic bit starts_with(int len, string p);
      if (len < p.len()) return 0;
      for (int i = 0; i < p.len(); i++)
         if (line_chars[i] != p[i]) return 0;
      return 1;
   endfunction

   // reply that a line end produces from the held line; 0 when none
   function automatic bit line_reply(output reply_t r);
      int    len;
      int    pos;
      int    mag;
      bit    neg;
      bit    ok;
      int    target;
      int    head;
      r = '0;
      if (line_len == 0) return 0;
      len = line_len;
      line_len = 0;
      for (int i = 0; i < len; i++)
         if (line_chars[i] == 8'h00) begin
            len = i;
            break;
         end
      head = 0;
      r.status = ST_FORMAT;
      if (starts_with(len, "FREQ=")) begin
         head = 5;
         r.status = ST_OK_LONG;
      end else if (starts_with(len, "F=")) begin
         head = 2;
         r.status = ST_OK_SHORT;
      end else if (len == 4 && starts_with(len, "HELP")) begin
         r.status = ST_HELP;
      end
      if (head != 0) begin
         pos = head;
         mag = 0;
         neg = 0;
         while (pos < len && is_space(line_chars[pos])) pos++;
         if (pos < len && (line_chars[pos] == "+" || line_chars[pos] == "-")) begin
            neg = line_chars[pos] == "-";
            pos++;
         end
         while (pos < len && line_chars[pos] >= "0" && line_chars[pos] <= "9") begin
            mag = mag * 10 + (line_chars[pos] - "0");
            if (mag > 1000000) mag = 1000000;
            pos++;
         end
         ok = !(neg && mag != 0) && mag >= 1000 && mag <= 100000;
         if (ok) begin
            freq_now = 17'(mag);
            target = 72000000 / mag;
            r.freq = 17'(mag);
            r.psc = 1'(target / 65536);
            r.reload = 16'(target / (r.psc + 1) - 1);
            r.compare = 16'((r.reload + 1) / 2);
         end else begin
            r.status = ST_RANGE;
         end
      end
      return 1;
   endfunction

   function automatic void take_char(logic [7:0] c);
      reply_t r;
      if (c != CH_CR && c != CH_LF) begin
         if (line_len < LINE_CHARS) begin
            line_chars[line_len] = c;
            line_len++;
         end
      end else if (line_reply(r)) begin
         pending_replies.push_back(r);
      end
   endfunction

   // one beat on the byte channel, with random idle cycles first
   task automatic send_char(logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      take_char(c);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   // random line: mostly well-formed commands with random values
   function automatic string random_line();
      string s;
      int    kind;
      int    n;
      kind = $urandom_range(9);
      case (kind)
         0, 1, 2: s = $sformatf("FREQ=%0d", $urandom_range(100000, 1000));
         3, 4:    s = $sformatf("F=%0d", $urandom_range(100000, 1000));
         5: begin
            s = $urandom_range(1) ? "F=" : "FREQ=";
            n = $urandom_range(6);
            repeat (n) s = {s, string'($urandom_range(1) ? " " : "\t")};
            case ($urandom_range(3))
               0: s = {s, "-"};
               1: s = {s, "+"};
               default: ;
            endcase
            s = {s, $sformatf("%0d", $urandom_range(9999999))};
            if ($urandom_range(1)) s = {s, "x9"};
         end
         6: s = $urandom_range(1) ? "HELP" : "HELPX";
         default: begin
            n = $urandom_range(40, 1);
            s = "";
            repeat (n) begin
               logic [7:0] c;
               c = 8'($urandom_range(255));
               if (c == CH_CR || c == CH_LF) c = 8'h00;
               s = {s, string'(c)};
            end
         end
      endcase
      return s;
   endfunction

   // reply side: random stalls and comparison at each accepted beat
   always @(posedge clock) begin
      reply_t got;
      reply_t want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_reply_status, rsp_new_frequency, rsp_prescale_value,
                    rsp_reload_value, rsp_compare_value};
            if (pending_replies.size() == 0) begin
               $display("%0t: unexpected reply beat %h", $time, got);
               failed = 1;
            end else begin
               want = pending_replies.pop_front();
               if (got.status !== want.status)
                  $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
               if (got.freq !== want.freq)
                  $display("%0t: frequency exp %0d got %0d", $time, want.freq, got.freq);
               if (got.psc !== want.psc)
                  $display("%0t: prescaler exp %0d got %0d", $time, want.psc, got.psc);
               if (got.reload !== want.reload)
                  $display("%0t: reload exp %0d got %0d", $time, want.reload, got.reload);
               if (got.compare !== want.compare)
                  $display("%0t: compare exp %0d got %0d", $time, want.compare,
                           got.compare);
               if (got !== want) failed = 1;
            end
         end
         rsp_stall <= $urandom_range(99) < stall_pct;
      end
   end

   // cycle counter with timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   line_row_t rows [$];
   reply_t    typed_reply;

   initial begin
      failed        = 0;
      cycles        = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      line_len      = 0;
      freq_now      = 17'd10000;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= 8'h00;
      rsp_stall   <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows; typed replies where obvious, the rest from the predictor
      rows.push_back('{"HELP",          1, '{ST_HELP, 0, 0, 0, 0}});
      rows.push_back('{"FREQ=1000",     1, '{ST_OK_LONG, 1000, 1, 35999, 18000}});
      rows.push_back('{"F=100000",      1, '{ST_OK_SHORT, 100000, 0, 719, 360}});
      rows.push_back('{"FREQ=999",      1, '{ST_RANGE, 0, 0, 0, 0}});
      rows.push_back('{"F=100001",      1, '{ST_RANGE, 0, 0, 0, 0}});
      rows.push_back('{"F=-5000",       1, '{ST_RANGE, 0, 0, 0, 0}});
      rows.push_back('{"F=99999999999", 1, '{ST_RANGE, 0, 0, 0, 0}});
      rows.push_back('{"F=",            1, '{ST_RANGE, 0, 0, 0, 0}});
      rows.push_back('{"F=-0",          1, '{ST_RANGE, 0, 0, 0, 0}});
      rows.push_back('{"HELPME",        1, '{ST_FORMAT, 0, 0, 0, 0}});
      rows.push_back('{"help",          1, '{ST_FORMAT, 0, 0, 0, 0}});
      rows.push_back('{"F= \t+1099",    0, '0});
      rows.push_back('{"FREQ=2000abc",  0, '0});
      rows.push_back('{"FREQ=1099",     0, '0});
      rows.push_back('{"F=12345~zz",    0, '0});
      rows.push_back('{"~~",            1, '{ST_FORMAT, 0, 0, 0, 0}});
      rows.push_back('{"FREQ=0000000000000000000000005000xyz", 0, '0});
      rows.push_back('{"\xff\x80\x7f\x01", 1, '{ST_FORMAT, 0, 0, 0, 0}});

      foreach (rows[i]) begin
         for (int k = 0; k < rows[i].text.len(); k++)
            send_char(rows[i].text[k] == ZERO_MARK ? 8'h00 : rows[i].text[k]);
         send_char($urandom_range(1) ? CH_CR : CH_LF);
         if (rows[i].typed) begin
            typed_reply = pending_replies[pending_replies.size() - 1];
            if (typed_reply !== rows[i].reply) begin
               $display("%0t: row %0d exp %h predictor %h", $time, i, rows[i].reply,
                        typed_reply);
               failed = 1;
            end
         end
         // empty line between: no reply expected
         send_char(CH_LF);
      end

      // random part in four phases of send idling and reply stalls
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? (phase == 3 ? 28 : 76) : 0;
         stall_pct     = (phase == 2 || phase == 3) ? (phase == 3 ? 28 : 76) : 0;
         repeat (11) begin
            send_text(random_line());
            send_char($urandom_range(1) ? CH_CR : CH_LF);
            if ($urandom_range(4) == 0) send_char(CH_CR);
         end
      end
      req_valid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> serial_freq_command_to_pwm_timer.f
+incdir+rtl/core
rtl/core/sfpt_pkg.sv
rtl/core/sfpt_datapath.sv
rtl/core/sfpt_ctrl.sv
rtl/core/serial_freq_command_to_pwm_timer.sv
tb/serial_freq_command_to_pwm_timer_tb.sv
